// ===== sv/rram_pkg.sv =====
`default_nettype none
package rram_pkg;
  localparam int SLOTS_DEF = 512;
  localparam int DW = 48;

  localparam logic [1:0] MODE_OFF     = 2'd0;
  localparam logic [1:0] MODE_LEARN   = 2'd1;
  localparam logic [1:0] MODE_PROTECT = 2'd2;

  localparam logic [1:0] REG_MODE      = 2'd0;
  localparam logic [1:0] REG_INTERVAL  = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_EL_DIV,
    ST_RATE_SETUP,
    ST_RATE_DIV,
    ST_RATE_MUL,
    ST_RATE_CMP,
    ST_FINISH,
    ST_OUT
  } state_t;
endpackage
`default_nettype wire

// ===== sv/resource_rate_anomaly_monitor.sv =====
`default_nettype none
// Resource-rate anomaly monitor.
// Input channel in_*: one sample per transfer (slot, pid, time, cumulative
// counters). Result channel out_*: one five-field result per sample.
// Configuration: cfg_we/cfg_index/cfg_data, to be written only while idle
// (the block does not enforce this). Each sample is handled by a sequencer
// around one shared 48-bit restoring divider (one quotient bit per cycle).
// An ignored sample goes straight to the output register; a first,
// restarted or unknown sample passes read, check and finish; a zero elapsed
// count adds the elapsed division, and otherwise the elapsed count and four
// rates are divided (per rate: setup, division, multiply, compare).
// in_tready is high only while the sequencer is idle, so no new sample is
// taken before the last one is through. A stalled receiver holds the result
// in the output register; the next result then waits in the sequencer and
// the input stalls. After reset a clearing pass over all SLOTS entries
// (512 by default) zeroes the track and learn valid bits; in_tready stays
// low meanwhile. Tables are read with a registered read and written once
// at the end of each processed sample.
module resource_rate_anomaly_monitor #(
  parameter int SLOTS = rram_pkg::SLOTS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // slot_index[8:0], proc_pid[30:9], sample_time, user_cpu, system_cpu,
  // read_total, write_total, vm_size, thread_count; zero pad to 320 bits
  input  wire logic [319:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // first_seen, restarted, unknown_binary, alert_mask[4:0], max_raised
  output logic [15:0]       out_tdata,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [9:0]   cfg_data
);
  localparam int AW = $clog2(SLOTS);
  localparam int DW = rram_pkg::DW;

  // input fields
  logic [8:0]    f_slot;
  logic [21:0]   f_pid;
  logic [DW-1:0] f_t, f_u, f_s, f_r, f_w;
  logic [31:0]   f_vm;
  logic [15:0]   f_th;
  assign f_slot = in_tdata[8:0];
  assign f_pid  = in_tdata[30:9];
  assign f_t    = in_tdata[78:31];
  assign f_u    = in_tdata[126:79];
  assign f_s    = in_tdata[174:127];
  assign f_r    = in_tdata[222:175];
  assign f_w    = in_tdata[270:223];
  assign f_vm   = in_tdata[302:271];
  assign f_th   = in_tdata[318:303];

  // configuration
  logic [1:0] mode_r;
  logic [7:0] ival_r;
  logic [9:0] thr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= rram_pkg::MODE_OFF;
      ival_r <= 8'd1;
      thr_r  <= 10'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rram_pkg::REG_MODE:      mode_r <= cfg_data[1:0];
        rram_pkg::REG_INTERVAL:  ival_r <= cfg_data[7:0];
        rram_pkg::REG_THRESHOLD: thr_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // memories
  logic [22+5*DW-1:0] trk_mem [SLOTS];
  logic [4*DW+48-1:0] max_mem [SLOTS];
  logic [1:0]         vld_mem [SLOTS];
  logic [22+5*DW-1:0] trk_rd_r;
  logic [4*DW+48-1:0] max_rd_r;
  logic [1:0]         vld_rd_r;
  logic               tv_hit, lv_hit;
  assign tv_hit = vld_rd_r[0];
  assign lv_hit = vld_rd_r[1];

  // clearing pass of the valid bits after reset
  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(SLOTS - 1)) clr_busy_r <= 1'b0;
    end
  end

  rram_pkg::state_t state_r, state_nxt;

  // sample holding registers
  logic [AW-1:0] slot_r;
  logic [21:0]   pid_r;
  logic [DW-1:0] t_r, u_r, s_r, r_r, w_r;
  logic [31:0]   vm_r;
  logic [15:0]   th_r;

  // working registers
  logic [DW-1:0] el_r;
  logic [DW-1:0] mx_r [4];
  logic [31:0]   mvm_r;
  logic [15:0]   mth_r;
  logic [1:0]    k_r;
  logic [DW-1:0] rate_r;
  logic [DW+10:0] prod_r;
  logic          first_r, restart_r, unknown_r, raised_r, lvset_r, wr_r;
  logic [4:0]    alert_r;

  // output register
  logic          out_valid_r;
  logic [8:0]    out_data_r;
  logic          out_load;

  // shared divider
  logic [DW-1:0] dv_n_r, dv_d_r, dv_q_r, dv_rem_r;
  logic [5:0]    dv_cnt_r;
  logic [DW:0]   dv_try;
  logic          dv_done;
  assign dv_try  = {dv_rem_r, dv_n_r[DW-1]} - {1'b0, dv_d_r};
  assign dv_done = (dv_cnt_r == 6'd0);

  logic accept;
  assign in_tready = (state_r == rram_pkg::ST_IDLE) && !clr_busy_r;
  assign accept = in_tvalid && in_tready;

  logic active;
  assign active = ((mode_r == rram_pkg::MODE_LEARN) || (mode_r == rram_pkg::MODE_PROTECT))
                  && ({23'd0, f_slot} < 32'(SLOTS));

  assign out_load = (state_r == rram_pkg::ST_OUT) && (!out_valid_r || out_tready);

  // stored values
  logic [21:0]   st_pid;
  logic [DW-1:0] st_t, st_u, st_s, st_r, st_w;
  assign st_pid = trk_rd_r[21:0];
  assign st_t = trk_rd_r[22+:DW];
  assign st_u = trk_rd_r[22+DW+:DW];
  assign st_s = trk_rd_r[22+2*DW+:DW];
  assign st_r = trk_rd_r[22+3*DW+:DW];
  assign st_w = trk_rd_r[22+4*DW+:DW];

  logic [DW-1:0] cur_delta;
  always_comb begin
    case (k_r)
      2'd0: cur_delta = u_r - st_u;
      2'd1: cur_delta = s_r - st_s;
      2'd2: cur_delta = r_r - st_r;
      default: cur_delta = w_r - st_w;
    endcase
  end

  // rate < min(floor(prod / 100), 2^32 - 1) holds when 100 * (rate + 1) <= prod
  // and the rate is below the saturation value
  logic [DW+10:0] rate_scaled;
  logic           rate_below_tol;
  assign rate_scaled    = ({11'd0, rate_r} + 59'd1) * 59'd100;
  assign rate_below_tol = (rate_r < 48'hFFFFFFFF) && (rate_scaled <= prod_r);

  // thread count never reaches the saturation value
  logic [31:0] th_prod;
  logic [31:0] th_scaled;
  logic        th_below_tol;
  assign th_prod      = {16'd0, mth_r} * {21'd0, 11'd100 + {1'b0, thr_r}};
  assign th_scaled    = ({16'd0, th_r} + 32'd1) * 32'd100;
  assign th_below_tol = (th_scaled <= th_prod);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rram_pkg::ST_IDLE:  if (accept) state_nxt = active ? rram_pkg::ST_READ : rram_pkg::ST_OUT;
      rram_pkg::ST_READ:  state_nxt = rram_pkg::ST_CHECK;
      rram_pkg::ST_CHECK: begin
        if (!tv_hit || pid_r != st_pid || u_r < st_u || s_r < st_s)
          state_nxt = rram_pkg::ST_FINISH;
        else if (mode_r == rram_pkg::MODE_PROTECT && !lv_hit)
          state_nxt = rram_pkg::ST_FINISH;
        else
          state_nxt = rram_pkg::ST_EL_DIV;
      end
      rram_pkg::ST_EL_DIV: if (dv_done)
        state_nxt = (dv_q_r == '0) ? rram_pkg::ST_FINISH : rram_pkg::ST_RATE_SETUP;
      rram_pkg::ST_RATE_SETUP: state_nxt = rram_pkg::ST_RATE_DIV;
      rram_pkg::ST_RATE_DIV:   if (dv_done) state_nxt = rram_pkg::ST_RATE_MUL;
      rram_pkg::ST_RATE_MUL:   state_nxt = rram_pkg::ST_RATE_CMP;
      rram_pkg::ST_RATE_CMP:
        state_nxt = (k_r == 2'd3) ? rram_pkg::ST_FINISH : rram_pkg::ST_RATE_SETUP;
      rram_pkg::ST_FINISH: state_nxt = rram_pkg::ST_OUT;
      rram_pkg::ST_OUT:    if (out_load) state_nxt = rram_pkg::ST_IDLE;
      default: state_nxt = rram_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= rram_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // tables: registered reads, track and valid written at FINISH, maxima
  // written once the thread and vm maxima have settled
  always_ff @(posedge clk) begin
    trk_rd_r <= trk_mem[slot_r];
    max_rd_r <= max_mem[slot_r];
    vld_rd_r <= vld_mem[slot_r];
    if (clr_busy_r) begin
      vld_mem[clr_addr_r] <= 2'b00;
    end else if (state_r == rram_pkg::ST_FINISH && wr_r) begin
      vld_mem[slot_r] <= {lv_hit | lvset_r, 1'b1};
    end
    if (state_r == rram_pkg::ST_FINISH && wr_r)
      trk_mem[slot_r] <= {w_r, r_r, s_r, u_r, t_r, pid_r};
    if (out_load && wr_r && (mode_r == rram_pkg::MODE_LEARN || lv_hit)
        && !first_r && !restart_r && !unknown_r)
      max_mem[slot_r] <= {mth_r, mvm_r, mx_r[3], mx_r[2], mx_r[1], mx_r[0]};
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      rram_pkg::ST_IDLE: if (accept) begin
        slot_r <= AW'(f_slot);
        pid_r <= f_pid; t_r <= f_t; u_r <= f_u; s_r <= f_s; r_r <= f_r; w_r <= f_w;
        vm_r <= f_vm; th_r <= f_th;
        wr_r <= active;
        first_r <= 1'b0; restart_r <= 1'b0; unknown_r <= 1'b0;
        raised_r <= 1'b0; alert_r <= 5'd0; lvset_r <= 1'b0;
      end
      rram_pkg::ST_CHECK: begin
        // load maxima, zero them for a fresh learned entry
        if (lv_hit) begin
          mx_r[0] <= max_rd_r[0+:DW];
          mx_r[1] <= max_rd_r[DW+:DW];
          mx_r[2] <= max_rd_r[2*DW+:DW];
          mx_r[3] <= max_rd_r[3*DW+:DW];
          mvm_r <= max_rd_r[4*DW+:32];
          mth_r <= max_rd_r[4*DW+32+:16];
        end else begin
          for (int i = 0; i < 4; i++) mx_r[i] <= '0;
          mvm_r <= '0; mth_r <= '0;
        end
        k_r <= 2'd0;
        if (!tv_hit) first_r <= 1'b1;
        else if (pid_r != st_pid || u_r < st_u || s_r < st_s) restart_r <= 1'b1;
        else if (mode_r == rram_pkg::MODE_PROTECT && !lv_hit) unknown_r <= 1'b1;
        else begin
          if (mode_r == rram_pkg::MODE_LEARN) lvset_r <= 1'b1;
          dv_n_r <= t_r - st_t;
          dv_d_r <= DW'((ival_r == 8'd0 ? 8'd1 : ival_r)) * DW'(1000);
          dv_rem_r <= '0;
          dv_cnt_r <= 6'(DW);
        end
      end
      rram_pkg::ST_EL_DIV, rram_pkg::ST_RATE_DIV: if (!dv_done) begin
        // restoring step: one quotient bit
        if (!dv_try[DW]) begin
          dv_rem_r <= dv_try[DW-1:0];
          dv_q_r   <= {dv_q_r[DW-2:0], 1'b1};
        end else begin
          dv_rem_r <= {dv_rem_r[DW-2:0], dv_n_r[DW-1]};
          dv_q_r   <= {dv_q_r[DW-2:0], 1'b0};
        end
        dv_n_r   <= {dv_n_r[DW-2:0], 1'b0};
        dv_cnt_r <= dv_cnt_r - 6'd1;
      end else if (state_r == rram_pkg::ST_EL_DIV) begin
        el_r <= dv_q_r;
      end else begin
        rate_r <= dv_q_r;
      end
      rram_pkg::ST_RATE_SETUP: begin
        dv_n_r <= cur_delta;
        dv_d_r <= el_r;
        dv_rem_r <= '0;
        dv_cnt_r <= 6'(DW);
      end
      rram_pkg::ST_RATE_MUL: prod_r <= {11'd0, mx_r[k_r]} * {48'd0, 11'd100 + {1'b0, thr_r}};
      rram_pkg::ST_RATE_CMP: begin
        if (rate_r > mx_r[k_r]) begin
          if (mode_r == rram_pkg::MODE_LEARN || rate_below_tol) begin
            mx_r[k_r] <= rate_r;
            raised_r <= 1'b1;
          end else alert_r[k_r] <= 1'b1;
        end
        k_r <= k_r + 2'd1;
      end
      rram_pkg::ST_FINISH: if (!first_r && !restart_r && !unknown_r) begin
        // threads and vm, checked once whatever the elapsed count
        if (th_r > mth_r) begin
          if (mode_r == rram_pkg::MODE_LEARN || th_below_tol) begin
            mth_r <= th_r; raised_r <= 1'b1;
          end else alert_r[4] <= 1'b1;
        end
        if (mode_r == rram_pkg::MODE_LEARN && vm_r > mvm_r) begin
          mvm_r <= vm_r; raised_r <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // hold the result while the receiver stalls, drop it after the transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
      out_data_r  <= {raised_r, alert_r, unknown_r, restart_r, first_r};
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_data_r};

  property p_hold_stalled;
    @(posedge clk) disable iff (!rst_n)
      (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata));
  endproperty
  assert property (p_hold_stalled) else $error("result changed while stalled");
  property p_no_accept_busy;
    @(posedge clk) disable iff (!rst_n)
      ((state_r != rram_pkg::ST_IDLE) || clr_busy_r) |-> !in_tready;
  endproperty
  assert property (p_no_accept_busy) else $error("ready while busy");
  property p_one_flag;
    @(posedge clk) disable iff (!rst_n) out_tvalid |-> $onehot0(out_tdata[2:0]);
  endproperty
  assert property (p_one_flag) else $error("exclusive outcome flags");
endmodule
`default_nettype wire
